@@ src/i2c_thermal_array_register_model_macros.svh @@
// Assertion macros for the thermal array register model.
// Used by the top level only; expects clk_i and rst_ni in scope.
`ifndef I2C_THERMAL_ARRAY_REGISTER_MODEL_MACROS_SVH
`define I2C_THERMAL_ARRAY_REGISTER_MODEL_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define I2CTA_ASSERT_IMP(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("i2cta assertion failed");

// Next-cycle implication.
`define I2CTA_ASSERT_NXT(label, cond, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error("i2cta assertion failed");

`endif

@@ src/i2cta_pkg.sv @@
// Shared types, constants and frame generation functions for the
// thermal array register model. No dependencies.
package i2cta_pkg;

  localparam int ADDR_W      = 8;
  localparam int DATA_W      = 8;
  localparam int STORE_DEPTH = 256;

  localparam int PIXEL_COUNT = 64;
  localparam int ROW_LENGTH  = 8;

  localparam logic [ADDR_W-1:0] PIXEL_BASE = 8'h80;
  localparam logic [ADDR_W-1:0] THERM_LO   = 8'h0E;
  localparam logic [ADDR_W-1:0] THERM_HI   = 8'h0F;
  localparam logic [ADDR_W-1:0] ADDR_MASK  = 8'hFF;

  localparam int TEMP_CAP    = 80;
  localparam int TEMP_OFFSET = 10;
  localparam logic [11:0] THERM_RAW = 12'(28 * 16);

  // refill writes two bytes per pixel, then the thermistor word
  localparam int REGEN_LEN = 2 * PIXEL_COUNT + 2;
  localparam int CNT_W     = ADDR_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int TEMP_W = 10;
  localparam int PIX_W  = 7;

  typedef enum logic [2:0] {
    ACT_START_WR = 3'd0,
    ACT_START_RD = 3'd1,
    ACT_WRITE    = 3'd2,
    ACT_READ     = 3'd3,
    ACT_STOP     = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_CLEAR,
    OP_WRITE,
    OP_READ
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_REGEN,
    ST_IDLE,
    ST_RDADDR,
    ST_RDATA
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [DATA_W-1:0] data;
  } queue_entry_t;

  typedef struct packed {
    logic init_busy;
  } back_status_t;

  // Store address of the refill step idx.
  function automatic logic [ADDR_W-1:0] regen_addr(logic [CNT_W-1:0] idx);
    logic [ADDR_W-1:0] a;
    if (idx < CNT_W'(2 * PIXEL_COUNT)) begin
      a = (PIXEL_BASE + ADDR_W'(idx)) & ADDR_MASK;
    end else if (idx == CNT_W'(2 * PIXEL_COUNT)) begin
      a = THERM_LO;
    end else begin
      a = THERM_HI;
    end
    return a;
  endfunction

  // Byte written at refill step idx for the given frame phase.
  function automatic logic [DATA_W-1:0] regen_byte(logic [CNT_W-1:0] idx,
                                                    logic [2:0] phase);
    logic [PIX_W-1:0]  pix;
    logic [PIX_W-1:0]  row;
    logic [PIX_W-1:0]  col;
    logic [TEMP_W-1:0] t;
    logic [11:0]       raw;
    logic [DATA_W-1:0] b;
    pix = PIX_W'(idx >> 1);
    row = PIX_W'(pix / PIX_W'(ROW_LENGTH));
    col = PIX_W'(pix % PIX_W'(ROW_LENGTH));
    t = TEMP_W'(TEMP_OFFSET) + TEMP_W'(row) * TEMP_W'(7) + (TEMP_W'(col) << 1)
        + TEMP_W'(phase);
    if (t > TEMP_W'(TEMP_CAP)) begin
      t = TEMP_W'(TEMP_CAP);
    end
    raw = {t, 2'b00};
    if (idx < CNT_W'(2 * PIXEL_COUNT)) begin
      b = idx[0] ? {4'h0, raw[11:8]} : raw[7:0];
    end else if (idx == CNT_W'(2 * PIXEL_COUNT)) begin
      b = THERM_RAW[7:0];
    end else begin
      b = {4'h0, THERM_RAW[11:8]};
    end
    return b;
  endfunction

endpackage

@@ src/i2c_thermal_array_register_model.sv @@
// Top level of the thermal array I2C register model.
// Depends on i2cta_pkg, i2cta_front, i2cta_back and the assertion macro header.
//
// Each bus event (start write, start read, write byte, read byte, stop) yields
// exactly one result beat with ack set. After reset the block takes no event
// until a pass zeroes the register store and frame 1 and the thermistor word
// are written. Events then pass through a two-entry queue to a sequencer around
// a single-write-port store: a write or control event loads the result register
// directly, a read byte first reads the store. A read byte with the pointer at
// 0x80 first rewrites the 128 pixel bytes and the thermistor word one byte a
// cycle through the store's single write port.
`include "i2c_thermal_array_register_model_macros.svh"

module i2c_thermal_array_register_model (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [2:0]                    action_i,
  input  logic [i2cta_pkg::DATA_W-1:0]  write_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [i2cta_pkg::DATA_W-1:0]  read_data_o,
  output logic                          ack_o
);
  import i2cta_pkg::*;

  logic         q_valid;
  queue_entry_t q_entry;
  logic         pop;
  back_status_t status;

  i2cta_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .write_data_i(write_data_i),
    .status_i    (status),
    .pop_i       (pop),
    .q_valid_o   (q_valid),
    .q_entry_o   (q_entry)
  );

  i2cta_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_entry_i  (q_entry),
    .pop_o      (pop),
    .status_o   (status),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .read_data_o(read_data_o)
  );

  // every event is acknowledged
  assign ack_o = 1'b1;

  `I2CTA_ASSERT_IMP(a_pop_needs_entry, pop, q_valid)
  `I2CTA_ASSERT_IMP(a_no_accept_in_init, in_valid_i && !in_stall_o, !status.init_busy)
  `I2CTA_ASSERT_IMP(a_no_result_in_init, status.init_busy, !out_valid_o && !q_valid)

endmodule

@@ src/i2cta_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module i2cta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold read data until the next read
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/i2cta_front.sv @@
// Front end: accepts bus events, classifies them and queues them for the back end.
// Depends on i2cta_pkg.
module i2cta_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [2:0]                     action_i,
  input  logic [i2cta_pkg::DATA_W-1:0]   write_data_i,
  input  i2cta_pkg::back_status_t        status_i,
  input  logic                           pop_i,
  output logic                           q_valid_o,
  output i2cta_pkg::queue_entry_t        q_entry_o
);
  import i2cta_pkg::*;

  queue_entry_t      entry_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;
  queue_entry_t      new_entry;
  logic              push;
  logic              full;

  always_comb begin
    new_entry.data = write_data_i;
    unique case (action_i)
      ACT_START_WR, ACT_STOP: new_entry.op = OP_CLEAR;
      ACT_WRITE:              new_entry.op = OP_WRITE;
      ACT_READ:               new_entry.op = OP_READ;
      default:                new_entry.op = OP_NONE;
    endcase
  end

  assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
  // take nothing while the store is being initialized
  assign in_stall_o = full || status_i.init_busy;
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign q_entry_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_entry;
    end
  end

endmodule

@@ src/i2cta_back.sv @@
// Back end: register pointer, frame counter, store sequencer and result register.
// Depends on i2cta_pkg and i2cta_ram.
module i2cta_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_valid_i,
  input  i2cta_pkg::queue_entry_t       q_entry_i,
  output logic                          pop_o,
  output i2cta_pkg::back_status_t       status_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [i2cta_pkg::DATA_W-1:0]  read_data_o
);
  import i2cta_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic              loaded_q, loaded_d;
  logic [31:0]       frame_q, frame_d;
  logic              read_pend_q, read_pend_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] read_data_q, read_data_d;

  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;
  logic              slot_free;
  logic              load_out;
  logic [DATA_W-1:0] load_val;

  i2cta_ram #(
    .WIDTH(DATA_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign slot_free = !out_valid_q || !out_stall_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (cnt_q == CNT_W'(STORE_DEPTH - 1)) state_d = ST_REGEN;
      end
      ST_REGEN: begin
        if (cnt_q == CNT_W'(REGEN_LEN - 1)) begin
          state_d = read_pend_q ? ST_RDADDR : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (q_valid_i && q_entry_i.op == OP_READ) begin
          state_d = (ptr_q == PIXEL_BASE) ? ST_REGEN : ST_RDATA;
        end
      end
      ST_RDADDR: state_d = ST_RDATA;
      ST_RDATA: begin
        if (slot_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    loaded_d    = loaded_q;
    frame_d     = frame_q;
    read_pend_d = read_pend_q;
    pop_o       = 1'b0;
    we          = 1'b0;
    waddr       = ptr_q;
    wdata       = q_entry_i.data;
    re          = 1'b0;
    raddr       = ptr_q;
    load_out    = 1'b0;
    load_val    = '0;
    unique case (state_q)
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = cnt_q;
        wdata = '0;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STORE_DEPTH - 1)) begin
          cnt_d       = '0;
          read_pend_d = 1'b0;
        end
      end
      ST_REGEN: begin
        we    = 1'b1;
        waddr = regen_addr(cnt_q);
        wdata = regen_byte(cnt_q, frame_q[4:2]);
        cnt_d = cnt_q + 1'b1;
      end
      ST_IDLE: begin
        if (q_valid_i) begin
          if (q_entry_i.op == OP_READ) begin
            pop_o = 1'b1;
            if (ptr_q == PIXEL_BASE) begin
              // refill the frame before the read
              frame_d     = frame_q + 1'b1;
              cnt_d       = '0;
              read_pend_d = 1'b1;
            end else begin
              re = 1'b1;
            end
          end else if (slot_free) begin
            pop_o    = 1'b1;
            load_out = 1'b1;
            unique case (q_entry_i.op)
              OP_CLEAR: loaded_d = 1'b0;
              OP_WRITE: begin
                if (!loaded_q) begin
                  ptr_d    = q_entry_i.data;
                  loaded_d = 1'b1;
                end else begin
                  we    = 1'b1;
                  ptr_d = ptr_q + 1'b1;
                end
              end
              default: ;
            endcase
          end
        end
      end
      ST_RDADDR: re = 1'b1;
      ST_RDATA: begin
        if (slot_free) begin
          load_out = 1'b1;
          load_val = rdata;
          ptr_d    = ptr_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_d = load_out || (out_valid_q && out_stall_i);
  assign read_data_d = load_out ? load_val : read_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      ptr_q       <= '0;
      loaded_q    <= 1'b0;
      frame_q     <= 32'd1;
      read_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ptr_q       <= ptr_d;
      loaded_q    <= loaded_d;
      frame_q     <= frame_d;
      read_pend_q <= read_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    read_data_q <= read_data_d;
  end

  assign status_o.init_busy = (state_q == ST_CLEAR) ||
                              (state_q == ST_REGEN && !read_pend_q);
  assign out_valid_o = out_valid_q;
  assign read_data_o = read_data_q;

endmodule
